@@ hw/rtl/smb_pkg.sv @@
// Package for the serially loaded bank mapper.
// Holds widths, reset values, register select codes and the commit struct.
// No dependencies.
package smb_pkg;

    localparam int PRG_BANKS = 16;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int BANK_W    = 5;
    localparam int LOAD_BITS = 5;
    localparam int COUNT_W   = 3;

    // Low five bits of the last 16K bank
    localparam logic [BANK_W-1:0] PRG_LAST_BANK = BANK_W'((PRG_BANKS - 1) % 32);
    localparam logic [BANK_W-1:0] CHR_HIGH_RESET = BANK_W'(1);

    localparam logic [COUNT_W-1:0] LAST_POS = COUNT_W'(LOAD_BITS - 1);

    // Control forced bits on a loader reset write, and control bit positions
    localparam logic [BANK_W-1:0] CTRL_RESET_SET = 5'h0C;
    localparam logic [BANK_W-1:0] PAIR_MASK      = 5'h1E;
    localparam int CTRL_CHR_4K_BIT   = 4;
    localparam int CTRL_PRG_MODE_BIT = 3;
    localparam int CTRL_PRG_SLOT_BIT = 2;
    localparam int DATA_RESET_BIT    = 7;
    localparam int ADDR_SEL_LSB      = 13;

    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG      = 2'd3
    } t_reg_sel;

    // What one accepted write does to the register file
    typedef struct packed {
        logic              advance;   // a write was accepted this cycle
        logic              clear;     // data bit 7 reset write
        logic              commit;    // fifth serial bit arrived
        t_reg_sel          sel;
        logic [BANK_W-1:0] value;
    } t_commit;

    typedef struct packed {
        logic [BANK_W-1:0] prg_low;
        logic [BANK_W-1:0] prg_high;
        logic [BANK_W-1:0] chr_low;
        logic [BANK_W-1:0] chr_high;
        logic              mirror;
    } t_map;

endpackage

@@ hw/rtl/smb_if.sv @@
// Valid/ready channel interfaces for the bank mapper write and result beats.
// Depends on smb_pkg for the field widths.
interface smb_wr_if import smb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output write_address, output write_data, input ready);
    modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

interface smb_map_if import smb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              committed;
    logic [BANK_W-1:0] prg_bank_low;
    logic [BANK_W-1:0] prg_bank_high;
    logic [BANK_W-1:0] chr_bank_low;
    logic [BANK_W-1:0] chr_bank_high;
    logic              mirror_vertical;

    modport source (output valid, output committed, output prg_bank_low,
                    output prg_bank_high, output chr_bank_low, output chr_bank_high,
                    output mirror_vertical, input ready);
    modport sink   (input valid, input committed, input prg_bank_low,
                    input prg_bank_high, input chr_bank_low, input chr_bank_high,
                    input mirror_vertical, output ready);
endinterface

@@ hw/rtl/serial_loaded_bank_mapper.sv @@
// Serially loaded bank mapper top level: one result beat for every write beat.
// A write beat taken at an edge is offered as a result beat from the next cycle.
// One write per cycle while o_map.ready holds; output register and ready path set the rate.
// Reset (synchronous, active low): loader empty, control 0, PRG low 0, PRG high last bank,
// CHR low 0, CHR high 1, horizontal mirroring; no result pending.
// Depends on smb_pkg, smb_if, smb_loader and smb_banks.
module serial_loaded_bank_mapper import smb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    smb_wr_if.sink    i_wr,
    smb_map_if.source o_map
);

    // Output register state
    logic    r_valid;
    logic    r_committed;
    t_map    r_result;
    logic    accept;
    t_commit commit;
    t_map    next_map;

    // Take a new beat whenever the output register is empty or drains this cycle
    assign i_wr.ready = !r_valid || o_map.ready;
    assign accept     = i_wr.valid && i_wr.ready;

    // Shift the serial bit and decide whether this beat commits
    smb_loader u_loader (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_address (i_wr.write_address),
        .i_data    (i_wr.write_data),
        .o_commit  (commit)
    );

    // Apply the commit and produce the mapping after this beat
    smb_banks u_banks (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (commit),
        .o_next_map (next_map)
    );

    // Result register: load on accept, drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_map.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_committed <= commit.commit;
            r_result    <= next_map;
        end
    end

    assign o_map.valid           = r_valid;
    assign o_map.committed       = r_committed;
    assign o_map.prg_bank_low    = r_result.prg_low;
    assign o_map.prg_bank_high   = r_result.prg_high;
    assign o_map.chr_bank_low    = r_result.chr_low;
    assign o_map.chr_bank_high   = r_result.chr_high;
    assign o_map.mirror_vertical = r_result.mirror;

`ifndef SYNTHESIS
    // A loader reset write never reports a commit
    a_clear_no_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_wr.write_data[DATA_RESET_BIT] |=> r_valid && !r_committed)
        else $error("reset write reported a commit");

    // A fifth serial bit shows up as a committed result
    a_commit_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && commit.commit |=> r_valid && r_committed)
        else $error("commit lost on the result beat");

    // Commit and loader clear are exclusive within one beat
    a_commit_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(commit.commit && commit.clear))
        else $error("commit and clear in the same beat");
`endif

endmodule

@@ hw/rtl/smb_loader.sv @@
// Five-bit serial loader: shifts data bit 0 in, LSB first, and flags the commit.
// Depends on smb_pkg.
module smb_loader import smb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_data,
    output t_commit           o_commit
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic [BANK_W-1:0]  r_buffer, n_buffer;
    logic [BANK_W-1:0]  shifted;
    logic               clear, last;

    assign clear   = i_data[DATA_RESET_BIT];
    assign last    = (r_count == LAST_POS);
    assign shifted = r_buffer | (BANK_W'(i_data[0]) << r_count);

    always_comb begin
        n_count  = r_count;
        n_buffer = r_buffer;
        if (i_accept) begin
            if (clear || last) begin
                n_count  = '0;
                n_buffer = '0;
            end else begin
                n_count  = r_count + COUNT_W'(1);
                n_buffer = shifted;
            end
        end
    end

    always_comb begin
        o_commit.advance = i_accept;
        o_commit.clear   = i_accept && clear;
        o_commit.commit  = i_accept && !clear && last;
        o_commit.sel     = t_reg_sel'(i_address[ADDR_SEL_LSB +: 2]);
        o_commit.value   = shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_buffer <= '0;
        end else begin
            r_count  <= n_count;
            r_buffer <= n_buffer;
        end
    end

endmodule

@@ hw/rtl/smb_banks.sv @@
// Control and bank registers; applies a committed value to its target register.
// Depends on smb_pkg. Drives the mapping as it stands after the current beat.
module smb_banks import smb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_commit i_commit,
    output t_map    o_next_map
);

    logic [BANK_W-1:0] r_control, n_control;
    t_map              r_map, n_map;
    logic [BANK_W-1:0] pair;

    assign pair = i_commit.value & PAIR_MASK;

    always_comb begin
        n_control = r_control;
        n_map     = r_map;
        if (i_commit.clear) begin
            n_control = r_control | CTRL_RESET_SET;
        end else if (i_commit.commit) begin
            case (i_commit.sel)
                SEL_CONTROL: begin
                    n_control    = i_commit.value;
                    n_map.mirror = i_commit.value[0];
                end
                SEL_CHR_LOW: begin
                    if (r_control[CTRL_CHR_4K_BIT]) begin
                        n_map.chr_low = i_commit.value;
                    end else begin
                        n_map.chr_low  = pair;
                        n_map.chr_high = pair | BANK_W'(1);
                    end
                end
                SEL_CHR_HIGH: begin
                    if (r_control[CTRL_CHR_4K_BIT]) begin
                        n_map.chr_high = i_commit.value;
                    end
                end
                SEL_PRG: begin
                    if (r_control[CTRL_PRG_MODE_BIT]) begin
                        if (r_control[CTRL_PRG_SLOT_BIT]) begin
                            n_map.prg_low = i_commit.value;
                        end else begin
                            n_map.prg_high = i_commit.value;
                        end
                    end else begin
                        n_map.prg_low  = pair;
                        n_map.prg_high = pair | BANK_W'(1);
                    end
                end
                default: begin
                    n_control = r_control;
                end
            endcase
        end
    end

    assign o_next_map = n_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control      <= '0;
            r_map.prg_low  <= '0;
            r_map.prg_high <= PRG_LAST_BANK;
            r_map.chr_low  <= '0;
            r_map.chr_high <= CHR_HIGH_RESET;
            r_map.mirror   <= 1'b0;
        end else begin
            r_control <= n_control;
            r_map     <= n_map;
        end
    end

endmodule

@@ tb/serial_loaded_bank_mapper_test.sv @@
// Self-checking testbench for serial_loaded_bank_mapper: random and directed CPU write
// beats in, one bank map beat out per write, checked against an internal mapper model.
// Depends on smb_pkg and the smb_wr_if / smb_map_if channel interfaces.
module serial_loaded_bank_mapper_test import smb_pkg::*; ();

    localparam int ITEM_TARGET  = 1150;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 4;

    // One expected or observed result beat
    typedef struct packed {
        logic committed;
        t_map banks;
    } map_beat_t;

    // Tracks the mapper state from accepted writes and holds the map beats still owed
    class bank_map_scoreboard;
        logic [COUNT_W-1:0] load_count;
        logic [BANK_W-1:0]  load_bits;
        logic [BANK_W-1:0]  control;
        t_map               map_now;
        map_beat_t          expected_maps[$];
        int                 errors;
        int                 writes;
        int                 results;
        int                 loads;
        int                 clears;

        function new();
            load_count       = '0;
            load_bits        = '0;
            control          = '0;
            map_now.prg_low  = '0;
            map_now.prg_high = BANK_W'(PRG_BANKS - 1);
            map_now.chr_low  = '0;
            map_now.chr_high = BANK_W'(1);
            map_now.mirror   = 1'b0;
            errors  = 0;
            writes  = 0;
            results = 0;
            loads   = 0;
            clears  = 0;
        endfunction

        function int pending();
            return expected_maps.size();
        endfunction

        // Apply a finished five-bit load to the register that the address selects
        function void commit_load(t_reg_sel sel, logic [BANK_W-1:0] value);
            logic [BANK_W-1:0] pair;
            pair = value & PAIR_MASK;
            case (sel)
                SEL_CONTROL: begin
                    control        = value;
                    map_now.mirror = value[0];
                end
                SEL_CHR_LOW: begin
                    if (control[CTRL_CHR_4K_BIT]) begin
                        map_now.chr_low = value;
                    end else begin
                        map_now.chr_low  = pair;
                        map_now.chr_high = pair | BANK_W'(1);
                    end
                end
                SEL_CHR_HIGH: begin
                    // 8K CHR mode ignores the high register entirely
                    if (control[CTRL_CHR_4K_BIT])
                        map_now.chr_high = value;
                end
                default: begin
                    if (control[CTRL_PRG_MODE_BIT]) begin
                        if (control[CTRL_PRG_SLOT_BIT])
                            map_now.prg_low = value;
                        else
                            map_now.prg_high = value;
                    end else begin
                        map_now.prg_low  = pair;
                        map_now.prg_high = pair | BANK_W'(1);
                    end
                end
            endcase
        endfunction

        function void note_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
            map_beat_t beat;
            beat.committed = 1'b0;
            writes++;
            if (wdata[DATA_RESET_BIT]) begin
                load_count = '0;
                load_bits  = '0;
                control    = control | CTRL_RESET_SET;
                clears++;
            end else begin
                load_bits[load_count] = wdata[0];
                if (load_count == COUNT_W'(LOAD_BITS - 1)) begin
                    commit_load(t_reg_sel'(addr[ADDR_SEL_LSB +: 2]), load_bits);
                    load_count     = '0;
                    load_bits      = '0;
                    beat.committed = 1'b1;
                    loads++;
                end else begin
                    load_count++;
                end
            end
            beat.banks = map_now;
            expected_maps.push_back(beat);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_map(map_beat_t got);
            map_beat_t want;
            results++;
            if (expected_maps.size() == 0) begin
                errors++;
                $display("%0t: map beat with nothing outstanding, actual %h", $time, got);
                return;
            end
            want = expected_maps.pop_front();
            compare_field("committed",       want.committed,      got.committed);
            compare_field("prg_bank_low",    want.banks.prg_low,  got.banks.prg_low);
            compare_field("prg_bank_high",   want.banks.prg_high, got.banks.prg_high);
            compare_field("chr_bank_low",    want.banks.chr_low,  got.banks.chr_low);
            compare_field("chr_bank_high",   want.banks.chr_high, got.banks.chr_high);
            compare_field("mirror_vertical", want.banks.mirror,   got.banks.mirror);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    smb_wr_if  wr_bus ();
    smb_map_if map_bus ();

    serial_loaded_bank_mapper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr_bus),
        .o_map   (map_bus)
    );

    bank_map_scoreboard sb;

    // Driver state; hold_cycles and calm are shared with the result sink
    int writes_sent = 0;
    int hold_cycles = 0;   // nonzero asks the sink for one long hold-off
    bit calm        = 1'b0; // no random idling on either side while set

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Sample both channels at the edge: note the write beat first, then check the result beat
    always @(posedge i_clk) begin
        map_beat_t got;
        if (i_rst_n) begin
            if (wr_bus.valid && wr_bus.ready)
                sb.note_write(wr_bus.write_address, wr_bus.write_data);
            if (map_bus.valid && map_bus.ready) begin
                got.committed      = map_bus.committed;
                got.banks.prg_low  = map_bus.prg_bank_low;
                got.banks.prg_high = map_bus.prg_bank_high;
                got.banks.chr_low  = map_bus.chr_bank_low;
                got.banks.chr_high = map_bus.chr_bank_high;
                got.banks.mirror   = map_bus.mirror_vertical;
                sb.check_map(got);
            end
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Mostly inside the 0x8000-0xFFFF window; the rest anywhere, bit 15 included
    function automatic logic [ADDR_W-1:0] rand_address();
        if ($urandom_range(0, 9) != 0)
            return {1'b1, 15'($urandom)};
        else
            return ADDR_W'($urandom);
    endfunction

    // Offer one write beat and hold it until the mapper takes it, then idle a random gap
    task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] wdata);
        int gap;
        wr_bus.valid         <= 1'b1;
        wr_bus.write_address <= addr;
        wr_bus.write_data    <= wdata;
        do @(posedge i_clk); while (!wr_bus.ready);
        writes_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            wr_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Shift five serial bits, LSB first; only the last write's address picks the target
    task automatic load_register(input logic [ADDR_W-1:0] addr, input logic [BANK_W-1:0] value,
                                 input bit fixed_fill, input logic [5:0] fill);
        logic [5:0] upper;
        for (int i = 0; i < LOAD_BITS; i++) begin
            upper = fixed_fill ? fill : 6'($urandom);
            send_write((i == LOAD_BITS - 1) ? addr : rand_address(), {1'b0, upper, value[i]});
        end
    endtask

    task automatic send_clear(input logic [ADDR_W-1:0] addr);
        send_write(addr, {1'b1, 7'($urandom)});
    endtask

    // Result sink: random ready pattern, plus one long hold-off when asked
    initial begin : result_sink
        int r;
        int run;
        map_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                run         = hold_cycles;
                hold_cycles = 0;
                map_bus.ready <= 1'b0;
                repeat (run) @(posedge i_clk);
            end else if (calm) begin
                map_bus.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    map_bus.ready <= 1'b1;
                    run = $urandom_range(1, 12);
                end else if (r < 90) begin
                    map_bus.ready <= 1'b0;
                    run = $urandom_range(1, 3);
                end else if (r < 98) begin
                    map_bus.ready <= 1'b0;
                    run = $urandom_range(4, 10);
                end else begin
                    map_bus.ready <= 1'b0;
                    run = $urandom_range(15, 30);
                end
                repeat (run) @(posedge i_clk);
            end
        end
    end

    initial begin : write_source
        int  r;
        int  n;
        bit  stall_done;
        bit  drain_done;
        sb = new();
        stall_done = 1'b0;
        drain_done = 1'b0;
        i_rst_n              <= 1'b0;
        wr_bus.valid         <= 1'b0;
        wr_bus.write_address <= '0;
        wr_bus.write_data    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: loader reset with all data bits high, at the top address
        send_write(16'hFFFF, 8'hFF);
        // Control = 0 with all-zero data bytes: 32K PRG, 8K CHR, horizontal
        load_register(16'h8000, 5'h00, 1'b1, 6'h00);
        // PRG 32K pair from an address below the window; data bits 6 to 1 all set
        load_register(16'h7FFF, 5'h15, 1'b1, 6'h3F);
        // Bare loader reset at address zero forces 16K PRG, low slot switchable
        send_write(16'h0000, 8'h80);
        // CHR low in 8K mode maps an even/odd pair
        load_register(16'hA000, 5'h1F, 1'b0, 6'h00);
        // CHR high in 8K mode must leave the map alone
        load_register(16'hC000, 5'h03, 1'b0, 6'h00);
        // 16K PRG low slot with a bank past the end of the ROM: no wrap
        load_register(16'hE000, 5'h1F, 1'b0, 6'h00);

        // Random: mostly complete loads, some aborted by a reset write, some noise
        while (writes_sent < ITEM_TARGET) begin
            if (!stall_done && writes_sent >= 300) begin
                // Hold the sink off while writes keep coming, so the input stalls
                stall_done  = 1'b1;
                hold_cycles = LONG_HOLD;
                calm        = 1'b1;
            end
            if (calm && writes_sent >= 420)
                calm = 1'b0;
            if (!drain_done && writes_sent >= 700) begin
                // Drop valid and let every owed map beat come out first
                drain_done = 1'b1;
                wr_bus.valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end

            r = $urandom_range(0, 99);
            if (r < 80) begin
                if ($urandom_range(0, 3) == 0)
                    send_clear(rand_address());
                load_register(rand_address(), BANK_W'($urandom), 1'b0, 6'h00);
            end else if (r < 90) begin
                n = $urandom_range(1, LOAD_BITS - 1);
                for (int i = 0; i < n; i++)
                    send_write(rand_address(), {1'b0, 7'($urandom)});
                send_clear(rand_address());
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_write(rand_address(), DATA_W'($urandom));
            end
        end

        // Drain: drop valid, wait for the last beats, then a few quiet cycles
        wr_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d write beats, %0d map beats checked, %0d register loads, %0d loader resets",
                 sb.writes, sb.results, sb.loads, sb.clears);
        $display("long sink hold-off, full drain pause and back-to-back bursts exercised");
        if (sb.errors == 0) begin
            $display("serial_loaded_bank_mapper_test: clean");
        end else begin
            $display("serial_loaded_bank_mapper_test: errors");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin : watchdog
        #(2 * CLK_HALF * 400000);
        $display("serial_loaded_bank_mapper_test: errors");
        $finish;
    end

endmodule
